@@ src/pcr_pkg.sv @@
// Shared constants, types and the CRC byte step of the pretrigger capture ring.
package pcr_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int PRE_FRAMES  = 768;
  localparam int POST_FRAMES = 256;
  localparam int PULL_MAX    = 32;
  localparam int FRAME_WORDS = 7;
  localparam int WORD_W      = 32;
  localparam int WSEL_W      = $clog2(FRAME_WORDS);
  localparam int POST_W      = $clog2(POST_FRAMES + 1);
  localparam int CNT_W       = $clog2(PULL_MAX + 1);
  localparam int WIN_FRAMES  = PRE_FRAMES + POST_FRAMES;
  localparam int SUM_W       = 14;
  localparam int PRE_MOD     = PRE_FRAMES % RING_DEPTH;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef logic [FRAME_WORDS-1:0][WORD_W-1:0] frame_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_PULL    = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CODE_DONE   = 3'd0,
    CODE_ACCEPT = 3'd1,
    CODE_REJECT = 3'd2,
    CODE_FRAME  = 3'd3,
    CODE_SUM    = 3'd4
  } code_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_POST   = 2'd1,
    MODE_FROZEN = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TRIG,
    ST_STATUS,
    ST_READ,
    ST_LATCH,
    ST_CRC,
    ST_FRAME,
    ST_SUM
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_FRAME,
    EMIT_SUM
  } emit_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_d_current;
    logic [31:0] sample_q_current;
    logic [31:0] sample_d_voltage;
    logic [31:0] sample_q_voltage;
    logic [31:0] sample_angle;
    logic [31:0] sample_q_target;
    logic [31:0] sample_stamp;
    logic [3:0]  trigger_source;
    logic [9:0]  pull_offset;
    logic [10:0] pull_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [1:0]  mode;
    logic [3:0]  source;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [31:0] word_e;
    logic [31:0] word_f;
    logic [31:0] word_g;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic  in_ready;
    logic  latch_in;
    logic  clr_step;
    logic  do_sample;
    logic  do_trigger;
    logic  do_clear;
    logic  pull_start;
    logic  rd_trig;
    logic  frame_latch;
    logic  crc_step;
    emit_t emit;
    code_t code;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    mode_t mode;
    logic  pull_ok;
    logic  clr_last;
    logic  crc_last;
    logic  cnt_zero;
    logic  out_free;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ src/pcr_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface pcr_in_if;
  logic                valid;
  logic                ready;
  pcr_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcr_out_if;
  logic                valid;
  logic                ready;
  pcr_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/pcr_ctrl.sv @@
// Controller state machine that sequences sweeps, commands, pulls and result emission.
module pcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  pcr_pkg::sts_t  sts,
  output pcr_pkg::cmd_t  cmd
);

  pcr_pkg::state_t state_r, state_nxt;
  pcr_pkg::code_t  code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcr_pkg::ST_CLEAR;
      code_r  <= pcr_pkg::CODE_DONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.emit  = pcr_pkg::EMIT_NONE;
    cmd.code  = code_r;
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      pcr_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = pcr_pkg::ST_IDLE;
      end
      pcr_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = pcr_pkg::ST_EXEC;
        end
      end
      pcr_pkg::ST_EXEC: begin
        unique case (sts.kind)
          pcr_pkg::KIND_SAMPLE: begin
            cmd.do_sample = 1'b1;
            code_nxt      = pcr_pkg::CODE_DONE;
            state_nxt     = pcr_pkg::ST_STATUS;
          end
          pcr_pkg::KIND_TRIGGER: begin
            if (sts.mode == pcr_pkg::MODE_IDLE) begin
              cmd.rd_trig = 1'b1;
              state_nxt   = pcr_pkg::ST_TRIG;
            end else begin
              code_nxt  = pcr_pkg::CODE_REJECT;
              state_nxt = pcr_pkg::ST_STATUS;
            end
          end
          pcr_pkg::KIND_PULL: begin
            if (sts.pull_ok) begin
              cmd.pull_start = 1'b1;
              state_nxt      = pcr_pkg::ST_READ;
            end else begin
              code_nxt  = pcr_pkg::CODE_REJECT;
              state_nxt = pcr_pkg::ST_STATUS;
            end
          end
          pcr_pkg::KIND_CLEAR: begin
            cmd.do_clear = 1'b1;
            code_nxt     = pcr_pkg::CODE_DONE;
            state_nxt    = pcr_pkg::ST_STATUS;
          end
        endcase
      end
      pcr_pkg::ST_TRIG: begin
        cmd.do_trigger = 1'b1;
        code_nxt       = pcr_pkg::CODE_ACCEPT;
        state_nxt      = pcr_pkg::ST_STATUS;
      end
      pcr_pkg::ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit  = pcr_pkg::EMIT_STATUS;
          state_nxt = pcr_pkg::ST_IDLE;
        end
      end
      pcr_pkg::ST_READ: begin
        state_nxt = pcr_pkg::ST_LATCH;
      end
      pcr_pkg::ST_LATCH: begin
        cmd.frame_latch = 1'b1;
        state_nxt       = pcr_pkg::ST_CRC;
      end
      pcr_pkg::ST_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_last) state_nxt = pcr_pkg::ST_FRAME;
      end
      pcr_pkg::ST_FRAME: begin
        if (sts.out_free) begin
          cmd.emit  = pcr_pkg::EMIT_FRAME;
          state_nxt = sts.cnt_zero ? pcr_pkg::ST_SUM : pcr_pkg::ST_READ;
        end
      end
      pcr_pkg::ST_SUM: begin
        if (sts.out_free) begin
          cmd.emit  = pcr_pkg::EMIT_SUM;
          state_nxt = pcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pcr_datapath.sv @@
// Datapath with the frame memory, capture state, pull window, CRC and result register.
module pcr_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pcr_pkg::cmd_t      cmd,
  input  pcr_pkg::in_item_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output pcr_pkg::out_item_t out_data,
  output pcr_pkg::sts_t      sts
);

  localparam int FRAME_BITS = pcr_pkg::FRAME_WORDS * pcr_pkg::WORD_W;

  logic [FRAME_BITS-1:0] mem [pcr_pkg::RING_DEPTH];

  pcr_pkg::in_item_t            in_r;
  pcr_pkg::mode_t               mode_r;
  logic [3:0]                   source_r;
  logic [pcr_pkg::IDX_W-1:0]    widx_r;
  logic [pcr_pkg::IDX_W-1:0]    tidx_r;
  logic [31:0]                  tstamp_r;
  logic [pcr_pkg::POST_W-1:0]   post_r;
  logic [pcr_pkg::POST_W-1:0]   post_nxt;
  logic [pcr_pkg::IDX_W-1:0]    clr_r;
  logic [pcr_pkg::IDX_W-1:0]    idx_r;
  logic [pcr_pkg::CNT_W-1:0]    cnt_r;
  logic [15:0]                  crc_r;
  logic [pcr_pkg::WSEL_W-1:0]   wsel_r;
  logic [1:0]                   bsel_r;
  pcr_pkg::frame_t              frame_r;
  pcr_pkg::frame_t              rdata_r;
  logic                         out_valid_r;
  pcr_pkg::out_item_t           out_r;
  pcr_pkg::out_item_t           out_nxt;

  logic                         mem_we;
  logic [pcr_pkg::IDX_W-1:0]    mem_waddr;
  logic [FRAME_BITS-1:0]        mem_wdata;
  logic [pcr_pkg::IDX_W-1:0]    rd_addr;
  logic [pcr_pkg::IDX_W-1:0]    prev_idx;
  logic [pcr_pkg::SUM_W-1:0]    win_end;
  logic [31:0]                  cur_word;
  logic [7:0]                   cur_byte;

  assign prev_idx  = widx_r - pcr_pkg::IDX_W'(1);
  assign mem_we    = cmd.clr_step | (cmd.do_sample & (mode_r != pcr_pkg::MODE_FROZEN));
  assign mem_waddr = cmd.clr_step ? clr_r : widx_r;
  assign mem_wdata = cmd.clr_step ? '0 :
                     {in_r.sample_stamp, in_r.sample_q_target, in_r.sample_angle,
                      in_r.sample_q_voltage, in_r.sample_d_voltage,
                      in_r.sample_q_current, in_r.sample_d_current};
  assign rd_addr   = cmd.rd_trig ? prev_idx : idx_r;
  assign post_nxt  = post_r + pcr_pkg::POST_W'(1);
  assign win_end   = pcr_pkg::SUM_W'(in_r.pull_offset) + pcr_pkg::SUM_W'(in_r.pull_length);
  assign cur_word  = frame_r[wsel_r];
  assign cur_byte  = cur_word[bsel_r*8 +: 8];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) in_r <= in_data;
    if (cmd.pull_start) begin
      idx_r <= tidx_r + in_r.pull_offset[pcr_pkg::IDX_W-1:0] - pcr_pkg::IDX_W'(pcr_pkg::PRE_MOD);
      cnt_r <= in_r.pull_length[pcr_pkg::CNT_W-1:0];
      crc_r <= pcr_pkg::CRC_INIT;
    end
    if (cmd.frame_latch) begin
      frame_r <= rdata_r;
      idx_r   <= idx_r + pcr_pkg::IDX_W'(1);
      cnt_r   <= cnt_r - pcr_pkg::CNT_W'(1);
      wsel_r  <= '0;
      bsel_r  <= '0;
    end
    if (cmd.crc_step) begin
      crc_r  <= pcr_pkg::crc_byte(crc_r, cur_byte);
      bsel_r <= bsel_r + 2'd1;
      if (bsel_r == 2'd3) wsel_r <= wsel_r + pcr_pkg::WSEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pcr_pkg::MODE_IDLE;
      source_r <= '0;
      widx_r   <= '0;
      tidx_r   <= '0;
      tstamp_r <= '0;
      post_r   <= '0;
      clr_r    <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + pcr_pkg::IDX_W'(1);
      if (cmd.do_sample && mode_r != pcr_pkg::MODE_FROZEN) begin
        widx_r <= widx_r + pcr_pkg::IDX_W'(1);
        if (mode_r == pcr_pkg::MODE_POST) begin
          post_r <= post_nxt;
          if (post_nxt >= pcr_pkg::POST_W'(pcr_pkg::POST_FRAMES)) mode_r <= pcr_pkg::MODE_FROZEN;
        end
      end
      if (cmd.do_trigger) begin
        tidx_r   <= prev_idx;
        tstamp_r <= rdata_r[pcr_pkg::FRAME_WORDS-1];
        post_r   <= '0;
        source_r <= in_r.trigger_source;
        mode_r   <= pcr_pkg::MODE_POST;
      end
      if (cmd.do_clear) begin
        mode_r   <= pcr_pkg::MODE_IDLE;
        source_r <= '0;
        post_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != pcr_pkg::EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.mode   = mode_r;
    out_nxt.source = source_r;
    unique case (cmd.emit)
      pcr_pkg::EMIT_STATUS: begin
        out_nxt.code   = cmd.code;
        out_nxt.word_a = 32'(post_r);
        out_nxt.word_b = tstamp_r;
        out_nxt.last   = 1'b1;
      end
      pcr_pkg::EMIT_FRAME: begin
        out_nxt.code   = pcr_pkg::CODE_FRAME;
        out_nxt.word_a = frame_r[0];
        out_nxt.word_b = frame_r[1];
        out_nxt.word_c = frame_r[2];
        out_nxt.word_d = frame_r[3];
        out_nxt.word_e = frame_r[4];
        out_nxt.word_f = frame_r[5];
        out_nxt.word_g = frame_r[6];
        out_nxt.last   = 1'b0;
      end
      pcr_pkg::EMIT_SUM: begin
        out_nxt.code   = pcr_pkg::CODE_SUM;
        out_nxt.word_a = {16'h0000, crc_r};
        out_nxt.last   = 1'b1;
      end
      default: begin
        out_nxt.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != pcr_pkg::EMIT_NONE) out_r <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.kind     = pcr_pkg::kind_t'(in_r.kind);
  assign sts.mode     = mode_r;
  assign sts.pull_ok  = (mode_r == pcr_pkg::MODE_FROZEN) && (in_r.pull_length != '0) &&
                        (in_r.pull_length <= 11'(pcr_pkg::PULL_MAX)) &&
                        (win_end <= pcr_pkg::SUM_W'(pcr_pkg::WIN_FRAMES));
  assign sts.clr_last = (clr_r == pcr_pkg::IDX_W'(pcr_pkg::RING_DEPTH - 1));
  assign sts.crc_last = (wsel_r == pcr_pkg::WSEL_W'(pcr_pkg::FRAME_WORDS - 1)) &&
                        (bsel_r == 2'd3);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ src/pretrigger_capture_ring.sv @@
// Top level of the pretrigger capture ring: controller plus datapath.
//
// The input channel carries one transaction per command: a sample frame, a
// trigger, a pull request or a clear. The result channel returns one status
// transaction per command, or for an accepted pull one frame transaction per
// requested frame followed by a checksum transaction marked last.
// After reset the block runs a clearing pass over the 1024 ring rows, one row
// per cycle, and takes no input transaction until it completes.
// A sample, clear or rejected command passes the execute and status states
// before its result is registered; an accepted trigger also passes the
// trigger state, for the stamp read. An accepted pull, for each frame, passes
// the registered memory read, the frame latch, the byte-serial CRC unit (28
// steps per frame) and the frame emission, then emits the checksum.
// Commands are handled one at a time; the next input transaction is taken
// while the last result still waits in the output register.
// When the receiver stalls, the output register holds its transaction and
// the controller waits before emitting the next one.
module pretrigger_capture_ring (
  input logic       clk,
  input logic       rst_n,
  pcr_in_if.sink    in_chan,
  pcr_out_if.source out_chan
);

  pcr_pkg::cmd_t cmd;
  pcr_pkg::sts_t sts;

  assign in_chan.ready = cmd.in_ready;

  pcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data),
    .sts       (sts)
  );

endmodule

@@ sim/pretrigger_capture_ring_test.sv @@
// Self-checking testbench for the pretrigger capture ring, with a predictor and directed and random commands.
module pretrigger_capture_ring_test;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 55;

  typedef struct {
    pcr_pkg::in_item_t  item;
    int                 reps;
    bit                 typed;
    pcr_pkg::out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  pcr_in_if  in_ch ();
  pcr_out_if out_ch ();

  pretrigger_capture_ring dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  logic [31:0]        ring_copy [pcr_pkg::RING_DEPTH][pcr_pkg::FRAME_WORDS];
  pcr_pkg::mode_t     cap_mode;
  logic [3:0]         cap_src;
  logic [9:0]         wr_idx;
  logic [9:0]         trig_idx;
  logic [31:0]        trig_stamp;
  logic [8:0]         post_cnt;

  pcr_pkg::out_item_t expected_results[$];
  stim_row_t          directed_rows[$];
  int                 mismatches;
  int                 cycles;
  int                 accepted;
  bit                 quiet;
  pcr_pkg::out_item_t got_result;
  pcr_pkg::out_item_t want_result;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic pcr_pkg::out_item_t status_of(pcr_pkg::code_t c);
    pcr_pkg::out_item_t r;
    r = '0;
    r.code = c;
    r.mode = cap_mode;
    r.source = cap_src;
    r.word_a = 32'(post_cnt);
    r.word_b = trig_stamp;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] crc_over_word(logic [15:0] crc, logic [31:0] w);
    logic [15:0] c;
    c = crc;
    for (int by = 0; by < 4; by++) begin
      c = c ^ {w[8*by +: 8], 8'h00};
      for (int b = 0; b < 8; b++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
    end
    return c;
  endfunction

  // Updates the capture state for one command and queues the results it causes.
  function automatic void predict_command(pcr_pkg::in_item_t it);
    pcr_pkg::out_item_t r;
    logic [9:0]         idx;
    logic [15:0]        crc;
    int                 len;
    int                 off;
    case (pcr_pkg::kind_t'(it.kind))
      pcr_pkg::KIND_SAMPLE: begin
        if (cap_mode != pcr_pkg::MODE_FROZEN) begin
          ring_copy[wr_idx][0] = it.sample_d_current;
          ring_copy[wr_idx][1] = it.sample_q_current;
          ring_copy[wr_idx][2] = it.sample_d_voltage;
          ring_copy[wr_idx][3] = it.sample_q_voltage;
          ring_copy[wr_idx][4] = it.sample_angle;
          ring_copy[wr_idx][5] = it.sample_q_target;
          ring_copy[wr_idx][6] = it.sample_stamp;
          wr_idx = wr_idx + 10'd1;
          if (cap_mode == pcr_pkg::MODE_POST) begin
            post_cnt = post_cnt + 9'd1;
            if (int'(post_cnt) >= pcr_pkg::POST_FRAMES) cap_mode = pcr_pkg::MODE_FROZEN;
          end
        end
        expected_results.push_back(status_of(pcr_pkg::CODE_DONE));
      end
      pcr_pkg::KIND_TRIGGER: begin
        if (cap_mode != pcr_pkg::MODE_IDLE) begin
          expected_results.push_back(status_of(pcr_pkg::CODE_REJECT));
        end else begin
          trig_idx = wr_idx - 10'd1;
          trig_stamp = ring_copy[trig_idx][6];
          post_cnt = '0;
          cap_src = it.trigger_source;
          cap_mode = pcr_pkg::MODE_POST;
          expected_results.push_back(status_of(pcr_pkg::CODE_ACCEPT));
        end
      end
      pcr_pkg::KIND_PULL: begin
        off = int'(it.pull_offset);
        len = int'(it.pull_length);
        if (cap_mode != pcr_pkg::MODE_FROZEN || len == 0 || len > pcr_pkg::PULL_MAX ||
            off + len > pcr_pkg::PRE_FRAMES + pcr_pkg::POST_FRAMES) begin
          expected_results.push_back(status_of(pcr_pkg::CODE_REJECT));
        end else begin
          idx = trig_idx + it.pull_offset - 10'(pcr_pkg::PRE_MOD);
          crc = 16'hFFFF;
          for (int f = 0; f < len; f++) begin
            r = status_of(pcr_pkg::CODE_FRAME);
            r.last = 1'b0;
            r.word_a = ring_copy[idx][0];
            r.word_b = ring_copy[idx][1];
            r.word_c = ring_copy[idx][2];
            r.word_d = ring_copy[idx][3];
            r.word_e = ring_copy[idx][4];
            r.word_f = ring_copy[idx][5];
            r.word_g = ring_copy[idx][6];
            for (int j = 0; j < pcr_pkg::FRAME_WORDS; j++)
              crc = crc_over_word(crc, ring_copy[idx][j]);
            expected_results.push_back(r);
            idx = idx + 10'd1;
          end
          r = status_of(pcr_pkg::CODE_SUM);
          r.word_a = {16'h0000, crc};
          r.word_b = '0;
          expected_results.push_back(r);
        end
      end
      default: begin
        cap_mode = pcr_pkg::MODE_IDLE;
        cap_src = '0;
        post_cnt = '0;
        expected_results.push_back(status_of(pcr_pkg::CODE_DONE));
      end
    endcase
  endfunction

  function automatic pcr_pkg::in_item_t make_item(pcr_pkg::kind_t k, logic [31:0] w,
                                                  logic [3:0] s, logic [9:0] o,
                                                  logic [10:0] l);
    pcr_pkg::in_item_t it;
    it.kind = k;
    it.sample_d_current = w;
    it.sample_q_current = ~w;
    it.sample_d_voltage = {w[15:0], w[31:16]};
    it.sample_q_voltage = w ^ 32'h0F0F_F0F0;
    it.sample_angle = {w[7:0], w[31:8]};
    it.sample_q_target = w + 32'd1;
    it.sample_stamp = w ^ 32'hA5A5_5A5A;
    it.trigger_source = s;
    it.pull_offset = o;
    it.pull_length = l;
    return it;
  endfunction

  function automatic pcr_pkg::in_item_t random_item(pcr_pkg::kind_t k);
    pcr_pkg::in_item_t it;
    it = make_item(k, $urandom, 4'($urandom), 10'($urandom),
                   11'($urandom_range(0, 1024)));
    it.sample_q_current = $urandom;
    it.sample_d_voltage = $urandom;
    it.sample_q_voltage = $urandom;
    it.sample_angle = $urandom;
    it.sample_q_target = $urandom;
    it.sample_stamp = $urandom;
    return it;
  endfunction

  task automatic add_row(pcr_pkg::kind_t k, logic [31:0] w, logic [3:0] s, logic [9:0] o,
                         logic [10:0] l, int reps, bit typed, pcr_pkg::code_t c,
                         pcr_pkg::mode_t m, logic [3:0] esrc, logic [31:0] wa,
                         logic [31:0] wb);
    stim_row_t row;
    row.item = make_item(k, w, s, o, l);
    row.reps = reps;
    row.typed = typed;
    row.want = '0;
    row.want.code = c;
    row.want.mode = m;
    row.want.source = esrc;
    row.want.word_a = wa;
    row.want.word_b = wb;
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endtask

  // Presents one command, waits until it is accepted and then predicts it.
  task automatic send_command(pcr_pkg::in_item_t it, bit typed, pcr_pkg::out_item_t want);
    quiet = (accepted >= 100 && accepted < 200);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    accepted++;
    predict_command(it);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  task automatic send_plain(pcr_pkg::in_item_t it);
    send_command(it, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_result = out_ch.data;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got_result);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.code !== want_result.code || got_result.mode !== want_result.mode ||
            got_result.source !== want_result.source ||
            got_result.word_a !== want_result.word_a ||
            got_result.word_b !== want_result.word_b ||
            got_result.word_c !== want_result.word_c ||
            got_result.word_d !== want_result.word_d ||
            got_result.word_e !== want_result.word_e ||
            got_result.word_f !== want_result.word_f ||
            got_result.word_g !== want_result.word_g ||
            got_result.last !== want_result.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %p", want_result);
            $display("                 actual   %p", got_result);
          end
        end
      end
    end
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 17);
  end

  initial begin
    pcr_pkg::in_item_t it;
    int pick;
    int off;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    accepted = 0;
    quiet = 1'b0;
    for (int i = 0; i < pcr_pkg::RING_DEPTH; i++)
      for (int j = 0; j < pcr_pkg::FRAME_WORDS; j++) ring_copy[i][j] = '0;
    cap_mode = pcr_pkg::MODE_IDLE;
    cap_src = '0;
    wr_idx = '0;
    trig_idx = '0;
    trig_stamp = '0;
    post_cnt = '0;

    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 1, 1, 1,
            pcr_pkg::CODE_REJECT, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_TRIGGER, 0, 15, 0, 0, 1, 1,
            pcr_pkg::CODE_ACCEPT, pcr_pkg::MODE_POST, 15, 0, 0);
    add_row(pcr_pkg::KIND_TRIGGER, 0, 5, 0, 0, 1, 1,
            pcr_pkg::CODE_REJECT, pcr_pkg::MODE_POST, 15, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 1, 1, 1,
            pcr_pkg::CODE_REJECT, pcr_pkg::MODE_POST, 15, 0, 0);
    add_row(pcr_pkg::KIND_CLEAR, 0, 0, 0, 0, 1, 1,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 1, 1,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 32'h0, 0, 0, 0, 1, 1,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 32'h5A5A_0FF0, 0, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_TRIGGER, 0, 0, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 0, 0, 0, 0, 255, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 32'h8000_0001, 0, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_SAMPLE, 32'h1234_5678, 0, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_TRIGGER, 0, 9, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 0, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 33, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 1024, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 1023, 2, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 1023, 1, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 0, 32, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 992, 32, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);
    add_row(pcr_pkg::KIND_PULL, 0, 0, 767, 3, 1, 0,
            pcr_pkg::CODE_DONE, pcr_pkg::MODE_IDLE, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        it = directed_rows[r].item;
        if (directed_rows[r].reps > 1) it = random_item(pcr_pkg::KIND_SAMPLE);
        send_command(it, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        it = random_item(pcr_pkg::KIND_PULL);
        if ($urandom_range(0, 99) < 80) begin
          off = $urandom_range(0, 1023);
          it.pull_offset = 10'(off);
          it.pull_length = 11'($urandom_range(1, (1024 - off < 8) ? 1024 - off : 8));
        end
      end else if (pick < 75) begin
        it = random_item(pcr_pkg::KIND_SAMPLE);
      end else if (pick < 92) begin
        it = random_item(pcr_pkg::KIND_TRIGGER);
      end else begin
        it = random_item(pcr_pkg::KIND_CLEAR);
      end
      send_plain(it);
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
